// ----- hdl/cse_pkg.sv -----
// Constants and the sequencer state type of the cosine similarity engine.
// Standalone package; imported by cosine_similarity_engine.
package cse_pkg;

   localparam int ELEM_BITS = 16;            // element width, Q1.15
   localparam int DOT_W     = 42;            // signed dot product accumulator
   localparam int NORM_W    = 41;            // unsigned squared-norm accumulators
   localparam int HALF_W    = 21;            // operand width of the shared multiplier
   localparam int PROD_W    = 2 * HALF_W;    // multiplier product width
   localparam int NN_W      = 2 * NORM_W;    // norm_a * norm_b
   localparam int M2_W      = 2 * PROD_W;    // |dot| squared (two halves each side)
   localparam int REF_SHIFT = 32;            // right-hand side is |dot|^2 * 2^32
   localparam int REF_W     = M2_W + REF_SHIFT;
   localparam int SUM_W     = 114;           // (2m+1)^2 * nn for m < 2^15
   localparam int P_W       = 98;            // (2m+1) * nn
   localparam int M_W       = 15;            // searched value m = q - 1
   localparam int Q_W       = 16;
   localparam int BIT_W     = 4;
   localparam int SHIFT_W   = 5;
   localparam int MULJ_W    = 4;
   localparam int MUL_STEPS = 8;             // four partial products each for norm_a * norm_b and |dot|^2

   localparam logic signed [DOT_W:0] DOT_MAX_EXT = {2'b00, {(DOT_W - 1){1'b1}}};
   localparam logic signed [DOT_W:0] DOT_MIN_EXT = {2'b11, {(DOT_W - 1){1'b0}}};
   localparam logic [NORM_W-1:0]     NORM_MAX    = {NORM_W{1'b1}};
   localparam logic [Q_W-1:0]        SIM_MAX     = {1'b0, {(Q_W - 1){1'b1}}};

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_ELEM = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_INIT = 7'b0001000,
      ST_ADD  = 7'b0010000,
      ST_CMP  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      EL_AB    = 2'd0,
      EL_AA    = 2'd1,
      EL_BB    = 2'd2,
      EL_FLUSH = 2'd3
   } elem_step_type;

endpackage

// ----- hdl/cosine_similarity_engine.sv -----
// Cosine similarity engine: streaming accumulate of dot product and norms, then an
// exact rounded quotient dot / sqrt(na * nb) by a bitwise search. Uses cse_pkg.

// Element pairs arrive on the req_ stream (elem_a in tdata[15:0], elem_b in
// tdata[31:16], tlast marks the final pair); one Q1.15 result per vector pair
// leaves on rsp_ with tuser flagging a zero norm. All products go through one
// shared 21x21 multiplier: an element pair passes the transfer, three products
// and the last accumulate. After the final pair come the eight partial products
// of norm_a*norm_b and |dot|^2, the first test, the 15 bit search steps (add,
// then compare against the 116-bit reference) and the load of the output
// register. A held result does not block the next vector's element transfers.
module cosine_similarity_engine
   import cse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] elem_a, [31:16] elem_b
   input  logic        req_tlast,    // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [15:0] similarity
   output logic        rsp_tuser     // [0] zero_norm
);

   state_type            state_ff, state_in;
   elem_step_type        step_ff, step_in;
   logic [MULJ_W-1:0]    mulj_ff, mulj_in;
   logic [ELEM_BITS-1:0] a_mag_ff, a_mag_in, b_mag_ff, b_mag_in;
   logic                 neg_ff, neg_in;
   logic                 last_ff, last_in;
   logic [DOT_W-1:0]     dot_ff, dot_in;
   logic [NORM_W-1:0]    na_ff, na_in, nb_ff, nb_in;
   logic [PROD_W-1:0]    prod_ff;
   logic [NN_W-1:0]      nn_ff, nn_in;
   logic [M2_W-1:0]      m2_ff, m2_in;
   logic [SUM_W-1:0]     s_ff, s_in, t_ff, t_in;
   logic [P_W-1:0]       p_ff, p_in;
   logic [M_W-1:0]       m_ff, m_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic                 found_ff, found_in;
   logic                 zero_ff, zero_in;
   logic                 dneg_ff, dneg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [Q_W-1:0]       rsp_sim_ff, rsp_sim_in;
   logic                 rsp_zero_ff, rsp_zero_in;

   logic [HALF_W-1:0]    mul_x, mul_y;
   logic [PROD_W-1:0]    mul_p;
   logic [ELEM_BITS-1:0] in_a, in_b;
   logic signed [DOT_W:0] dot_term, dot_sum;
   logic [NORM_W:0]      norm_base, norm_sum;
   logic [NORM_W-1:0]    norm_sat;
   logic [DOT_W-1:0]     dot_mag;
   logic [PROD_W-1:0]    na_wide, nb_wide, word_x, word_y;
   logic [MULJ_W-1:0]    mulj_m1;
   logic [2:0]           pidx;
   logic [M2_W-1:0]      acc_term;
   logic [SHIFT_W-1:0]   sh_p, sh_n, sh_pn;
   logic [SUM_W-1:0]     trial;
   logic [REF_W-1:0]     ref_rhs;
   logic                 init_ok, cmp_ok;
   logic [Q_W-1:0]       q_val;
   logic                 out_free;

   // shared multiplier
   assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

   assign in_a = req_tdata[15:0];
   assign in_b = req_tdata[31:16];
   assign dot_mag = dot_ff[DOT_W-1] ? (~dot_ff + DOT_W'(1)) : dot_ff;
   assign na_wide = PROD_W'(na_ff);
   assign nb_wide = PROD_W'(nb_ff);
   assign mulj_m1 = mulj_ff - MULJ_W'(1);
   assign pidx    = mulj_m1[2:0];
   assign ref_rhs = {m2_ff, {REF_SHIFT{1'b0}}};
   assign sh_p    = SHIFT_W'(bit_ff) + SHIFT_W'(2);
   assign sh_n    = {bit_ff, 1'b0} + SHIFT_W'(2);
   assign sh_pn   = SHIFT_W'(bit_ff) + SHIFT_W'(1);
   assign trial   = s_ff + (SUM_W'(p_ff) << sh_p) + (SUM_W'(nn_ff) << sh_n);
   assign init_ok = REF_W'(nn_ff) <= ref_rhs;
   assign cmp_ok  = REF_W'(t_ff) <= ref_rhs;
   assign q_val   = found_ff ? (Q_W'(m_ff) + Q_W'(1)) : '0;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sim_ff;
   assign rsp_tuser  = rsp_zero_ff;

   // saturating accumulators
   always_comb begin
      dot_term = signed'({1'b0, prod_ff});
      if (neg_ff) begin
         dot_term = -dot_term;
      end
      dot_sum = signed'({dot_ff[DOT_W-1], dot_ff}) + dot_term;
      norm_base = (step_ff == EL_BB) ? {1'b0, na_ff} : {1'b0, nb_ff};
      norm_sum  = norm_base + prod_ff;
      norm_sat  = norm_sum[NORM_W] ? NORM_MAX : norm_sum[NORM_W-1:0];
   end

   // operand selection and partial-product alignment
   always_comb begin
      word_x = mulj_ff[2] ? PROD_W'(dot_mag) : na_wide;
      word_y = mulj_ff[2] ? PROD_W'(dot_mag) : nb_wide;
      mul_x  = '0;
      mul_y  = '0;
      if (state_ff == ST_ELEM) begin
         case (step_ff)
            EL_AB: begin
               mul_x = HALF_W'(a_mag_ff);
               mul_y = HALF_W'(b_mag_ff);
            end
            EL_AA: begin
               mul_x = HALF_W'(a_mag_ff);
               mul_y = HALF_W'(a_mag_ff);
            end
            EL_BB: begin
               mul_x = HALF_W'(b_mag_ff);
               mul_y = HALF_W'(b_mag_ff);
            end
            default: begin
               mul_x = '0;
               mul_y = '0;
            end
         endcase
      end else begin
         mul_x = mulj_ff[1] ? word_x[PROD_W-1:HALF_W] : word_x[HALF_W-1:0];
         mul_y = mulj_ff[0] ? word_y[PROD_W-1:HALF_W] : word_y[HALF_W-1:0];
      end
      case (pidx[1:0])
         2'd0:    acc_term = M2_W'(prod_ff);
         2'd3:    acc_term = M2_W'(prod_ff) << (2 * HALF_W);
         default: acc_term = M2_W'(prod_ff) << HALF_W;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      mulj_in      = mulj_ff;
      a_mag_in     = a_mag_ff;
      b_mag_in     = b_mag_ff;
      neg_in       = neg_ff;
      last_in      = last_ff;
      dot_in       = dot_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      nn_in        = nn_ff;
      m2_in        = m2_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      p_in         = p_ff;
      m_in         = m_ff;
      bit_in       = bit_ff;
      found_in     = found_ff;
      zero_in      = zero_ff;
      dneg_in      = dneg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sim_in   = rsp_sim_ff;
      rsp_zero_in  = rsp_zero_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               a_mag_in = in_a[ELEM_BITS-1] ? (~in_a + ELEM_BITS'(1)) : in_a;
               b_mag_in = in_b[ELEM_BITS-1] ? (~in_b + ELEM_BITS'(1)) : in_b;
               neg_in   = in_a[ELEM_BITS-1] ^ in_b[ELEM_BITS-1];
               last_in  = req_tlast;
               step_in  = EL_AB;
               state_in = ST_ELEM;
            end
         end
         ST_ELEM: begin
            case (step_ff)
               EL_AB: begin
                  step_in = EL_AA;
               end
               EL_AA: begin
                  if (dot_sum > DOT_MAX_EXT) begin
                     dot_in = DOT_MAX_EXT[DOT_W-1:0];
                  end else if (dot_sum < DOT_MIN_EXT) begin
                     dot_in = DOT_MIN_EXT[DOT_W-1:0];
                  end else begin
                     dot_in = dot_sum[DOT_W-1:0];
                  end
                  step_in = EL_BB;
               end
               EL_BB: begin
                  na_in   = norm_sat;
                  step_in = EL_FLUSH;
               end
               default: begin
                  nb_in = norm_sat;
                  if (last_ff) begin
                     mulj_in  = '0;
                     nn_in    = '0;
                     m2_in    = '0;
                     state_in = ST_MUL;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_MUL: begin
            if (mulj_ff == '0) begin
               dneg_in = dot_ff[DOT_W-1];
               zero_in = (na_ff == '0) || (nb_ff == '0);
               if ((na_ff == '0) || (nb_ff == '0)) begin
                  state_in = ST_DONE;
               end
            end else begin
               if (pidx[2]) begin
                  m2_in = m2_ff + acc_term;
               end else begin
                  nn_in = nn_ff + acc_term[NN_W-1:0];
               end
            end
            if (mulj_ff == MULJ_W'(MUL_STEPS)) begin
               state_in = ST_INIT;
            end else if (!((mulj_ff == '0) && ((na_ff == '0) || (nb_ff == '0)))) begin
               mulj_in = mulj_ff + MULJ_W'(1);
            end
         end
         ST_INIT: begin
            // m = 0 (q = 1) must hold, else the rounded result is zero
            found_in = init_ok;
            s_in     = SUM_W'(nn_ff);
            p_in     = P_W'(nn_ff);
            m_in     = '0;
            bit_in   = BIT_W'(M_W - 1);
            state_in = init_ok ? ST_ADD : ST_DONE;
         end
         ST_ADD: begin
            t_in     = trial;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (cmp_ok) begin
               s_in         = t_ff;
               p_in         = p_ff + P_W'(SUM_W'(nn_ff) << sh_pn);
               m_in[bit_ff] = 1'b1;
            end
            if (bit_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               bit_in   = bit_ff - BIT_W'(1);
               state_in = ST_ADD;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_zero_in  = zero_ff;
               if (zero_ff) begin
                  rsp_sim_in = '0;
               end else if (dneg_ff) begin
                  rsp_sim_in = ~q_val + Q_W'(1);
               end else begin
                  rsp_sim_in = q_val[Q_W-1] ? SIM_MAX : q_val;
               end
               dot_in   = '0;
               na_in    = '0;
               nb_in    = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= EL_AB;
         mulj_ff      <= '0;
         dot_ff       <= '0;
         na_ff        <= '0;
         nb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         mulj_ff      <= mulj_in;
         dot_ff       <= dot_in;
         na_ff        <= na_in;
         nb_ff        <= nb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_mag_ff    <= a_mag_in;
      b_mag_ff    <= b_mag_in;
      neg_ff      <= neg_in;
      last_ff     <= last_in;
      prod_ff     <= mul_p;
      nn_ff       <= nn_in;
      m2_ff       <= m2_in;
      s_ff        <= s_in;
      t_ff        <= t_in;
      p_ff        <= p_in;
      m_ff        <= m_in;
      bit_ff      <= bit_in;
      found_ff    <= found_in;
      zero_ff     <= zero_in;
      dneg_ff     <= dneg_in;
      rsp_sim_ff  <= rsp_sim_in;
      rsp_zero_ff <= rsp_zero_in;
   end

endmodule
